FILE: rtl/nvme_queue_pair_tracker_macros.svh
// assertion macros shared by the queue pair tracker rtl
// expects a clock named clk and an active-low reset named rst_n in scope
`ifndef NVME_QUEUE_PAIR_TRACKER_MACROS_SVH
`define NVME_QUEUE_PAIR_TRACKER_MACROS_SVH

// same-cycle implication, disabled during reset
`define NQPT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define NQPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/nqpt_pkg.sv
// shared types, constants and ring helpers for the queue pair tracker
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package nqpt_pkg;

  localparam int SLOT_COUNT = 64;
  localparam int IDX_W      = $clog2(SLOT_COUNT);
  localparam int CFG_W      = IDX_W + 1;
  localparam int CID_W      = 16;

  localparam logic [CFG_W-1:0] QUEUE_ENTRIES_RST = CFG_W'(SLOT_COUNT);
  localparam logic [CFG_W-1:0] RING_MIN          = CFG_W'(2);
  localparam logic [CFG_W-1:0] RING_MAX          = CFG_W'(SLOT_COUNT);

  typedef enum logic [2:0] {
    OUT_SUBMITTED  = 3'd0,
    OUT_FULL       = 3'd1,
    OUT_SLOT_BUSY  = 3'd2,
    OUT_DONE_OK    = 3'd3,
    OUT_DONE_ERR   = 3'd4,
    OUT_BAD_ID     = 3'd5,
    OUT_NOT_ACTIVE = 3'd6,
    OUT_BATCH_END  = 3'd7
  } outcome_t;

  typedef enum logic [1:0] {
    RING_NONE = 2'd0,
    RING_SQ   = 2'd1,
    RING_CQ   = 2'd2
  } ring_kind_t;

  localparam logic FUNC_SUBMIT = 1'b0;

  // ring size in use: register clamped to 2..SLOT_COUNT
  function automatic logic [CFG_W-1:0] ring_size(input logic [CFG_W-1:0] q);
    logic [CFG_W-1:0] n;
    n = q;
    if (n < RING_MIN) n = RING_MIN;
    if (n > RING_MAX) n = RING_MAX;
    return n;
  endfunction

  // step a ring pointer, wrapping to zero at or beyond the last entry
  function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] p,
                                               input logic [CFG_W-1:0] n);
    logic [CFG_W-1:0] p1;
    p1 = {1'b0, p} + CFG_W'(1);
    return (p1 < n) ? p1[IDX_W-1:0] : '0;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/nvme_queue_pair_tracker.sv
// host-side nvme submission/completion queue pair tracker, top level
// depends on nqpt_pkg and nvme_queue_pair_tracker_macros.svh
// holds ring pointers, the expected phase and the per-slot active flags
`timescale 1ns / 1ps
`default_nettype none

// usage
// - input channel (in_valid/in_ready): one event per transfer; in_func low is
//   a submit request, high is a completion entry seen at the head, with its
//   phase, reported submission head, command id and status
// - result channel (out_valid/out_ready): exactly one result per event, the
//   outcome code, the slot id and an optional doorbell write (kind and value)
// - cfg_we/cfg_wdata write the ring size; write only while the block is idle
// - latency: the result of an event is valid in the cycle after its transfer
// - throughput: one event per cycle while out_ready is high; all bookkeeping is a single pass of
//   compare-and-advance logic between the input ports and the result register,
//   the pointer state updating at the same edge the event transfers
// - stall: the result register holds while out_ready is low; in_ready stays
//   high as long as the result register is empty or being drained this cycle
// - reset (rst_n low, synchronous): pointers zero, expected phase one, every
//   slot inactive, ring size register back to 64, result register empty
module nvme_queue_pair_tracker (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [nqpt_pkg::CFG_W-1:0] cfg_wdata,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic                      in_func,
  input  wire logic                      in_entry_phase,
  input  wire logic [nqpt_pkg::IDX_W-1:0] in_entry_sq_head,
  input  wire logic [nqpt_pkg::CID_W-1:0] in_entry_command_id,
  input  wire logic [2:0]                in_entry_code_type,
  input  wire logic [7:0]                in_entry_code,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [2:0]                     out_outcome,
  output logic [nqpt_pkg::IDX_W-1:0]     out_slot_id,
  output logic [1:0]                     out_ring_kind,
  output logic [nqpt_pkg::IDX_W-1:0]     out_ring_value
);

  import nqpt_pkg::*;

  `include "nvme_queue_pair_tracker_macros.svh"

  // configuration
  logic [CFG_W-1:0] queue_entries_r;
  logic [CFG_W-1:0] ring_n;

  // ring bookkeeping state
  logic [IDX_W-1:0]      sub_tail_r, sub_tail_nxt;
  logic [IDX_W-1:0]      sub_head_seen_r, sub_head_seen_nxt;
  logic [IDX_W-1:0]      comp_head_r, comp_head_nxt;
  logic                  ready_phase_r, ready_phase_nxt;
  logic                  batch_handled_r, batch_handled_nxt;
  logic [SLOT_COUNT-1:0] slot_active_r, slot_active_nxt;

  // result register
  logic             out_valid_r;
  outcome_t         outcome_r, outcome_nxt;
  logic [IDX_W-1:0] slot_id_r, slot_id_nxt;
  ring_kind_t       ring_kind_r, ring_kind_nxt;
  logic [IDX_W-1:0] ring_value_r, ring_value_nxt;

  logic             in_xfer;
  logic [IDX_W-1:0] tail_adv;
  logic [IDX_W-1:0] head_adv;
  logic [IDX_W-1:0] cid_idx;
  logic             cid_in_range;
  logic             status_ok;

  // a new event transfers whenever the result slot is free or draining
  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;

  assign ring_n       = ring_size(queue_entries_r);
  assign tail_adv     = advance(sub_tail_r, ring_n);
  assign head_adv     = advance(comp_head_r, ring_n);
  assign cid_idx      = in_entry_command_id[IDX_W-1:0];
  assign cid_in_range = in_entry_command_id < CID_W'(ring_n);
  assign status_ok    = (in_entry_code_type == 3'd0) && (in_entry_code == 8'd0);

  // event evaluation: next state and the result it produces
  always_comb begin
    sub_tail_nxt      = sub_tail_r;
    sub_head_seen_nxt = sub_head_seen_r;
    comp_head_nxt     = comp_head_r;
    ready_phase_nxt   = ready_phase_r;
    batch_handled_nxt = batch_handled_r;
    slot_active_nxt   = slot_active_r;
    outcome_nxt       = OUT_BATCH_END;
    slot_id_nxt       = '0;
    ring_kind_nxt     = RING_NONE;
    ring_value_nxt    = '0;

    if (in_func == FUNC_SUBMIT) begin
      // submit: refuse when full or when the tail slot is still in flight
      slot_id_nxt = sub_tail_r;
      if (tail_adv == sub_head_seen_r) begin
        outcome_nxt = OUT_FULL;
      end else if (slot_active_r[sub_tail_r]) begin
        outcome_nxt = OUT_SLOT_BUSY;
      end else begin
        slot_active_nxt[sub_tail_r] = 1'b1;
        sub_tail_nxt                = tail_adv;
        outcome_nxt                 = OUT_SUBMITTED;
        ring_kind_nxt               = RING_SQ;
        ring_value_nxt              = tail_adv;
      end
    end else if (in_entry_phase != ready_phase_r) begin
      // stale phase: batch ends, ring the completion doorbell if work was done
      outcome_nxt = OUT_BATCH_END;
      if (batch_handled_r) begin
        batch_handled_nxt = 1'b0;
        ring_kind_nxt     = RING_CQ;
        ring_value_nxt    = comp_head_r;
      end
    end else begin
      // fresh completion entry: always consumed
      batch_handled_nxt = 1'b1;
      comp_head_nxt     = head_adv;
      if (head_adv == '0) begin
        ready_phase_nxt = !ready_phase_r;
      end
      sub_head_seen_nxt = in_entry_sq_head;
      if (!cid_in_range) begin
        outcome_nxt = OUT_BAD_ID;
      end else if (!slot_active_r[cid_idx]) begin
        outcome_nxt = OUT_NOT_ACTIVE;
        slot_id_nxt = cid_idx;
      end else begin
        slot_active_nxt[cid_idx] = 1'b0;
        slot_id_nxt              = cid_idx;
        outcome_nxt              = status_ok ? OUT_DONE_OK : OUT_DONE_ERR;
      end
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      queue_entries_r <= QUEUE_ENTRIES_RST;
    end else if (cfg_we) begin
      queue_entries_r <= cfg_wdata;
    end
  end

  // bookkeeping state advances only on an input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_tail_r      <= '0;
      sub_head_seen_r <= '0;
      comp_head_r     <= '0;
      ready_phase_r   <= 1'b1;
      batch_handled_r <= 1'b0;
      slot_active_r   <= '0;
    end else if (in_xfer) begin
      sub_tail_r      <= sub_tail_nxt;
      sub_head_seen_r <= sub_head_seen_nxt;
      comp_head_r     <= comp_head_nxt;
      ready_phase_r   <= ready_phase_nxt;
      batch_handled_r <= batch_handled_nxt;
      slot_active_r   <= slot_active_nxt;
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload, loaded with each transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      outcome_r    <= outcome_nxt;
      slot_id_r    <= slot_id_nxt;
      ring_kind_r  <= ring_kind_nxt;
      ring_value_r <= ring_value_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_outcome    = outcome_r;
  assign out_slot_id    = slot_id_r;
  assign out_ring_kind  = ring_kind_r;
  assign out_ring_value = ring_value_r;

  // no doorbell write means a zero doorbell value
  `NQPT_ASSERT_NOW(a_no_ring_zero_value,
    out_valid && (out_ring_kind == RING_NONE), out_ring_value == '0,
    "doorbell value set without a doorbell write")

  // an accepted submission leaves its slot marked active
  `NQPT_ASSERT_NEXT(a_submit_marks_slot,
    in_xfer && (in_func == FUNC_SUBMIT) && (outcome_nxt == OUT_SUBMITTED),
    slot_active_r[$past(sub_tail_r)], "submitted slot not marked active")

  // the completion head only moves when an entry is consumed
  `NQPT_ASSERT_NOW(a_head_move_handled, !$stable(comp_head_r), batch_handled_r,
    "completion head moved without a consumed entry")

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// self-checking testbench for nvme_queue_pair_tracker: directed rows, then random phases
// depends on nqpt_pkg and the nvme_queue_pair_tracker rtl; no files, no arguments
`timescale 1ns / 1ps

module tb_top;
  import nqpt_pkg::*;

  // one event as it appears on the input channel
  typedef struct packed {
    logic        func;
    logic        phase;
    logic [5:0]  sq_head;
    logic [15:0] cid;
    logic [2:0]  ctype;
    logic [7:0]  code;
  } evt_t;

  // one result as it appears on the result channel
  typedef struct packed {
    outcome_t    outcome;
    logic [5:0]  slot;
    ring_kind_t  kind;
    logic [5:0]  value;
  } res_t;

  // directed row: either a ring size write or an event, optionally with a typed result
  typedef struct packed {
    logic        is_cfg;
    logic [6:0]  cfg_val;
    logic        pinned;
    evt_t        ev;
    res_t        want;
  } row_t;

  localparam int STALL_LIMIT = 2000;  // cycles without any transfer before giving up
  localparam int LONG_HOLD   = 150;   // receiver hold-off that backs up the input
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 50;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [6:0]  cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_func = 1'b0;
  logic        in_entry_phase = 1'b0;
  logic [5:0]  in_entry_sq_head = '0;
  logic [15:0] in_entry_command_id = '0;
  logic [2:0]  in_entry_code_type = '0;
  logic [7:0]  in_entry_code = '0;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic [2:0]  out_outcome;
  logic [5:0]  out_slot_id;
  logic [1:0]  out_ring_kind;
  logic [5:0]  out_ring_value;

  // typed result riding along with the event on the input channel
  logic        pin_on = 1'b0;
  res_t        pin_res = '0;

  // pacing knobs, percent chance per decision
  int          src_rate = 0;
  int          sink_rate = 0;
  bit          hold_req = 1'b0;
  int          hold_left = 0;
  int          stall_left = 0;

  int          err_count = 0;
  int          idle_cycles = 0;
  res_t        pending_results[$];
  row_t        dir_rows[$];

  // tracker state, mirrored from the block's bookkeeping
  logic [6:0]  trk_entries;
  logic [5:0]  trk_tail;
  logic [5:0]  trk_head_seen;
  logic [5:0]  trk_cq_head;
  logic        trk_phase;
  logic        trk_busy [0:63];
  logic        trk_batch;

  nvme_queue_pair_tracker i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_func             (in_func),
    .in_entry_phase      (in_entry_phase),
    .in_entry_sq_head    (in_entry_sq_head),
    .in_entry_command_id (in_entry_command_id),
    .in_entry_code_type  (in_entry_code_type),
    .in_entry_code       (in_entry_code),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_outcome         (out_outcome),
    .out_slot_id         (out_slot_id),
    .out_ring_kind       (out_ring_kind),
    .out_ring_value      (out_ring_value)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ring size in use: register clamped to 2..64
  function automatic logic [6:0] ring_len();
    logic [6:0] n;
    n = trk_entries;
    if (n < 7'd2) n = 7'd2;
    if (n > 7'd64) n = 7'd64;
    return n;
  endfunction

  // pointer step, wraps to zero at or beyond the last entry in use
  function automatic logic [5:0] step_ptr(input logic [5:0] p, input logic [6:0] n);
    return (({1'b0, p} + 7'd1) < n) ? p + 6'd1 : 6'd0;
  endfunction

  function automatic res_t mk_res(input outcome_t o, input logic [5:0] s,
                                  input ring_kind_t k, input logic [5:0] v);
    res_t r;
    r.outcome = o;
    r.slot = s;
    r.kind = k;
    r.value = v;
    return r;
  endfunction

  // apply one event to the tracker state and return the result it causes
  function automatic res_t track_event(input evt_t e);
    res_t       r;
    logic [6:0] n;
    logic [5:0] slot;
    logic [5:0] nxt;
    n = ring_len();
    if (e.func == FUNC_SUBMIT) begin
      slot = trk_tail;
      nxt = step_ptr(trk_tail, n);
      if (nxt == trk_head_seen) begin
        r = mk_res(OUT_FULL, slot, RING_NONE, 6'd0);
      end else if (trk_busy[slot]) begin
        r = mk_res(OUT_SLOT_BUSY, slot, RING_NONE, 6'd0);
      end else begin
        trk_busy[slot] = 1'b1;
        trk_tail = nxt;
        r = mk_res(OUT_SUBMITTED, slot, RING_SQ, nxt);
      end
      return r;
    end
    // stale phase tag: the batch is over, doorbell only if something was consumed
    if (e.phase != trk_phase) begin
      if (trk_batch) begin
        trk_batch = 1'b0;
        r = mk_res(OUT_BATCH_END, 6'd0, RING_CQ, trk_cq_head);
      end else begin
        r = mk_res(OUT_BATCH_END, 6'd0, RING_NONE, 6'd0);
      end
      return r;
    end
    trk_batch = 1'b1;
    trk_cq_head = step_ptr(trk_cq_head, n);
    if (trk_cq_head == 6'd0) trk_phase = ~trk_phase;
    trk_head_seen = e.sq_head;
    // id at or above the ring size is rejected, but the entry still counts as consumed
    if (e.cid >= {9'd0, n}) begin
      r = mk_res(OUT_BAD_ID, 6'd0, RING_NONE, 6'd0);
    end else if (!trk_busy[e.cid[5:0]]) begin
      r = mk_res(OUT_NOT_ACTIVE, e.cid[5:0], RING_NONE, 6'd0);
    end else begin
      trk_busy[e.cid[5:0]] = 1'b0;
      if (e.ctype == 3'd0 && e.code == 8'd0) r = mk_res(OUT_DONE_OK, e.cid[5:0], RING_NONE, 6'd0);
      else r = mk_res(OUT_DONE_ERR, e.cid[5:0], RING_NONE, 6'd0);
    end
    return r;
  endfunction

  // random event shaped by the current tracker state: submits and mostly sane completions
  // of busy slots with the expected phase, plus stale phases, stray ids and noise
  function automatic evt_t rand_evt();
    evt_t       e;
    logic [6:0] n;
    int         roll;
    int         tries;
    logic [5:0] id;
    n = ring_len();
    e.func = FUNC_SUBMIT;
    e.phase = 1'($urandom);
    e.sq_head = 6'($urandom);
    e.cid = 16'($urandom);
    e.ctype = 3'($urandom);
    e.code = 8'($urandom);
    roll = $urandom_range(0, 99);
    if (roll >= 45 && roll < 92) begin
      e.func = ~FUNC_SUBMIT;
      e.phase = ($urandom_range(0, 9) == 0) ? ~trk_phase : trk_phase;
      id = 6'($urandom_range(0, n - 1));
      for (tries = 0; tries < 8 && !trk_busy[id]; tries++) id = 6'($urandom_range(0, n - 1));
      if ($urandom_range(0, 19) != 0) e.cid = {10'd0, id};
      roll = $urandom_range(0, 9);
      // controller usually reports it has caught up with the tail
      if (roll < 6) e.sq_head = trk_tail;
      else if (roll < 9) e.sq_head = 6'($urandom_range(0, n - 1));
      if ($urandom_range(0, 3) != 0) begin
        e.ctype = 3'd0;
        e.code = 8'd0;
      end
    end else if (roll >= 92) begin
      e.func = 1'($urandom);
    end
    return e;
  endfunction

  function automatic evt_t sub_evt();
    evt_t e;
    e = '0;
    e.func = FUNC_SUBMIT;
    return e;
  endfunction

  function automatic evt_t cpl_evt(input logic ph, input logic [5:0] hd, input logic [15:0] id,
                                   input logic [2:0] ct, input logic [7:0] cd);
    evt_t e;
    e.func = ~FUNC_SUBMIT;
    e.phase = ph;
    e.sq_head = hd;
    e.cid = id;
    e.ctype = ct;
    e.code = cd;
    return e;
  endfunction

  function automatic void add_evt(input evt_t e, input logic pinned, input res_t want);
    row_t r;
    r = '0;
    r.ev = e;
    r.pinned = pinned;
    r.want = want;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_cfg(input logic [6:0] v);
    row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.cfg_val = v;
    dir_rows.push_back(r);
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      err_count++;
    end
  endfunction

  // offer the next event (table row or random); gap first, then hold valid until the transfer
  task automatic offer_next(input int idx);
    int   gap;
    evt_t e;
    gap = (src_rate != 0 && $urandom_range(0, 99) < src_rate) ? $urandom_range(1, 16) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    // tracker state is settled here: the previous transfer was already scored at a rising edge
    if (idx >= 0) begin
      e = dir_rows[idx].ev;
      pin_on <= dir_rows[idx].pinned;
      pin_res <= dir_rows[idx].want;
    end else begin
      e = rand_evt();
      pin_on <= 1'b0;
    end
    in_valid <= 1'b1;
    in_func <= e.func;
    in_entry_phase <= e.phase;
    in_entry_sq_head <= e.sq_head;
    in_entry_command_id <= e.cid;
    in_entry_code_type <= e.ctype;
    in_entry_code <= e.code;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // ring size write, only once the block has drained every outstanding result
  task automatic write_ring_size(input logic [6:0] v);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_wdata <= 7'($urandom);
  endtask

  // receiver pacing: long hold on request, random stall bursts otherwise
  always @(negedge clk) begin
    if (hold_req && hold_left == 0) begin
      hold_left = LONG_HOLD;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (sink_rate != 0 && $urandom_range(0, 99) < sink_rate) begin
      stall_left = $urandom_range(0, 15);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // scoreboard: results checked first, so a result can never match an event
  // that transfers at the same edge
  always @(posedge clk) begin : score
    res_t want;
    evt_t e;
    if (!rst_n) begin
      trk_entries = QUEUE_ENTRIES_RST;
      trk_tail = '0;
      trk_head_seen = '0;
      trk_cq_head = '0;
      trk_phase = 1'b1;
      trk_batch = 1'b0;
      for (int i = 0; i < 64; i++) trk_busy[i] = 1'b0;
      pending_results.delete();
    end else begin
      if (cfg_we) trk_entries = cfg_wdata;
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual outcome %0d slot %0d kind %0d value %0d",
                   $time, out_outcome, out_slot_id, out_ring_kind, out_ring_value);
          err_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("outcome", 16'(want.outcome), 16'(out_outcome));
          check_field("slot_id", 16'(want.slot), 16'(out_slot_id));
          check_field("ring_kind", 16'(want.kind), 16'(out_ring_kind));
          check_field("ring_value", 16'(want.value), 16'(out_ring_value));
        end
      end
      if (in_valid && in_ready) begin
        e.func = in_func;
        e.phase = in_entry_phase;
        e.sq_head = in_entry_sq_head;
        e.cid = in_entry_command_id;
        e.ctype = in_entry_code_type;
        e.code = in_entry_code;
        want = track_event(e);
        // typed rows override the prediction, the tracker state still advances
        if (pin_on) want = pin_res;
        pending_results.push_back(want);
      end
    end
  end

  // watchdog: any transfer on either channel resets the count
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, STALL_LIMIT, pending_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stim
    logic [6:0] ring_plan [PHASES];
    int         src_plan [PHASES];
    int         sink_plan [PHASES];
    logic [6:0] v;
    ring_plan = '{7'd2, 7'd1, 7'd127, 7'd5, 7'd0, 7'd64, 7'd3, 7'd64};
    src_plan  = '{25, 0, 40, 10, 0, 30, 15, 0};
    sink_plan = '{20, 35, 0, 10, 30, 0, 15, 0};

    // directed rows; state walk starts from reset with a 64-entry ring
    add_evt(cpl_evt(1'b0, 6'd0, 16'd0, 3'd0, 8'd0), 1'b1,
            mk_res(OUT_BATCH_END, 6'd0, RING_NONE, 6'd0));            // batch end, nothing consumed
    add_evt(cpl_evt(1'b1, 6'd0, 16'd0, 3'd0, 8'd0), 1'b0, '0);        // completion of idle slot
    add_evt(cpl_evt(1'b1, 6'd63, 16'hffff, 3'd7, 8'hff), 1'b1,
            mk_res(OUT_BAD_ID, 6'd0, RING_NONE, 6'd0));               // id far out of range
    add_evt(cpl_evt(1'b0, 6'd0, 16'd0, 3'd0, 8'd0), 1'b1,
            mk_res(OUT_BATCH_END, 6'd0, RING_CQ, 6'd2));              // batch end with doorbell
    add_evt(sub_evt(), 1'b1, mk_res(OUT_SUBMITTED, 6'd0, RING_SQ, 6'd1));
    add_evt(cpl_evt(1'b1, 6'd0, 16'd0, 3'd0, 8'd0), 1'b0, '0);        // done ok
    add_evt(sub_evt(), 1'b0, '0);
    add_evt(cpl_evt(1'b1, 6'd1, 16'd1, 3'd0, 8'd1), 1'b0, '0);        // done with error status
    add_cfg(7'd0);                                                    // clamps to a 2-entry ring
    add_evt(sub_evt(), 1'b0, '0);                                     // tail beyond shrunk ring
    add_evt(sub_evt(), 1'b1, mk_res(OUT_FULL, 6'd0, RING_NONE, 6'd0));
    add_evt(cpl_evt(1'b1, 6'd0, 16'd2, 3'd0, 8'd0), 1'b1,
            mk_res(OUT_BAD_ID, 6'd0, RING_NONE, 6'd0));               // id equal to ring size, head wraps
    add_evt(sub_evt(), 1'b0, '0);
    add_evt(sub_evt(), 1'b0, '0);
    add_evt(cpl_evt(1'b1, 6'd0, 16'd0, 3'd0, 8'd0), 1'b0, '0);        // old phase after wrap
    add_evt(cpl_evt(1'b0, 6'd1, 16'd0, 3'd0, 8'd0), 1'b0, '0);
    add_evt(sub_evt(), 1'b0, '0);
    add_evt(cpl_evt(1'b0, 6'd63, 16'd5, 3'd0, 8'd0), 1'b0, '0);       // reported head beyond ring
    add_evt(sub_evt(), 1'b0, '0);
    add_evt(sub_evt(), 1'b1, mk_res(OUT_SLOT_BUSY, 6'd1, RING_NONE, 6'd0));
    add_cfg(7'd127);                                                  // clamps to 64
    add_evt(sub_evt(), 1'b0, '0);
    add_evt(cpl_evt(1'b1, 6'd0, 16'd1, 3'd0, 8'd0), 1'b0, '0);
    add_evt(sub_evt(), 1'b0, '0);
    add_evt(cpl_evt(1'b1, 6'd5, 16'd64, 3'd0, 8'd0), 1'b1,
            mk_res(OUT_BAD_ID, 6'd0, RING_NONE, 6'd0));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    src_rate = 20;
    sink_rate = 20;
    for (int i = 0; i < dir_rows.size(); i++) begin
      if (dir_rows[i].is_cfg) write_ring_size(dir_rows[i].cfg_val);
      else offer_next(i);
    end

    // random phases, each behind a ring size write on an idle block
    for (int p = 0; p < PHASES; p++) begin
      v = (p == 3) ? 7'($urandom_range(0, 127)) : ring_plan[p];
      write_ring_size(v);
      src_rate = src_plan[p];
      sink_rate = sink_plan[p];
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // receiver backs off long enough to stall the input while events keep coming
        if (p == 2 && k == 5) hold_req = 1'b1;
        offer_next(-1);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
